@@ hw/rtl/mfb_pkg.sv @@
package mfb_pkg;

	localparam int ROW_BYTES_DEF = 8;
	localparam int ROWS_DEF = 32;

	// 3x5 font, two 4-wide rows per byte (high nibble first), three bytes a digit
	localparam logic [7:0] FONT [30] = '{
		8'hea, 8'haa, 8'he0,
		8'h4c, 8'h44, 8'he0,
		8'he2, 8'he8, 8'he0,
		8'he2, 8'he2, 8'he0,
		8'haa, 8'he2, 8'h20,
		8'he8, 8'he2, 8'he0,
		8'h88, 8'hea, 8'he0,
		8'he2, 8'h22, 8'h20,
		8'hea, 8'hea, 8'he0,
		8'hea, 8'he2, 8'h20
	};

	localparam logic [2:0] DIGIT_LAST_ROW = 3'd4;

	typedef enum logic [2:0] {
		OP_CLEAR  = 3'd0,
		OP_DOWN   = 3'd1,
		OP_UP     = 3'd2,
		OP_LEFT   = 3'd3,
		OP_RIGHT  = 3'd4,
		OP_SPRITE = 3'd5,
		OP_DIGIT  = 3'd6,
		OP_READ   = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		SW_CLEAR,
		SW_DOWN,
		SW_UP,
		SW_LEFT,
		SW_RIGHT
	} sweep_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SW_PRIME,
		ST_SW_LOAD,
		ST_SW_RD,
		ST_SW_WR,
		ST_DR_RD0,
		ST_DR_WR0,
		ST_DR_RD1,
		ST_DR_WR1,
		ST_RD_DATA
	} state_t;

	typedef struct packed {
		op_t        op;
		logic [5:0] x;
		logic [4:0] y;
		logic [3:0] width;
		logic [7:0] pattern;
		logic       new_sprite;
		logic [3:0] digit_value;
		logic [4:0] line_count;
		logic [7:0] byte_address;
	} cmd_t;

	typedef struct packed {
		logic       collision;
		logic [7:0] read_data;
	} rsp_t;

	// first font byte of a digit, value taken modulo 10
	function automatic logic [4:0] digit_base(input logic [3:0] v);
		logic [3:0] m;
		m = (v >= 4'd10) ? v - 4'd10 : v;
		return 5'(m * 3);
	endfunction

	// pixel row r (0..4) of a digit, left-aligned in the top nibble
	function automatic logic [7:0] font_bits(input logic [4:0] base, input logic [2:0] r);
		logic [4:0] idx;
		logic [7:0] b;
		idx = base + {3'b000, r[2:1]};
		b = FONT[idx];
		return r[0] ? {b[3:0], 4'h0} : {b[7:4], 4'h0};
	endfunction

	// top bits of the pattern, width saturated at eight
	function automatic logic [7:0] sprite_bits(input logic [7:0] pat, input logic [3:0] w);
		logic [7:0] m;
		m = (w >= 4'd8) ? 8'hff : ~(8'hff >> w);
		return pat & m;
	endfunction

endpackage

@@ hw/rtl/mfb_ram.sv @@
module mfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             re,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

@@ hw/rtl/mfb_ctrl.sv @@
module mfb_ctrl #(
	parameter int ROW_BYTES = 8,
	parameter int ROWS = 32,
	localparam int STORE = ROW_BYTES * ROWS,
	localparam int AW = (STORE > 1) ? $clog2(STORE) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  mfb_pkg::cmd_t cmd,
	output logic          done,
	output mfb_pkg::rsp_t rsp,
	output logic          mem_re,
	output logic          mem_we,
	output logic [AW-1:0] mem_addr,
	output logic [7:0]    mem_wdata,
	input  logic [7:0]    mem_rdata
);

	import mfb_pkg::*;

	localparam int RP = ROW_BYTES * 8;
	localparam int CW = $clog2(RP);
	localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int BW = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;

	// modulo tables for the narrow coordinate and byte-address fields
	logic [CW-1:0] xmod_tab [64];
	logic [RW-1:0] ymod_tab [32];
	logic [AW-1:0] amod_tab [256];

	for (genvar g = 0; g < 64; g++) begin : g_xmod
		assign xmod_tab[g] = CW'(g % RP);
	end
	for (genvar g = 0; g < 32; g++) begin : g_ymod
		assign ymod_tab[g] = RW'(g % ROWS);
	end
	for (genvar g = 0; g < 256; g++) begin : g_amod
		assign amod_tab[g] = AW'(g % STORE);
	end

	state_t        state_q, state_d;
	sweep_t        mode_q;
	logic [AW-1:0] i_q;
	logic [BW-1:0] col_q;
	logic          init_q;
	logic          digit_q;
	logic [2:0]    r_q;
	logic          acc_q;
	logic          done_q;
	logic [7:0]    cur_q;
	logic [AW-1:0] moved_q;
	logic [CW-1:0] xm_q;
	logic [RW-1:0] row_q;
	logic [7:0]    bits_q;
	logic [4:0]    fbase_q;
	rsp_t          rsp_q;

	logic accept;
	logic finish;
	logic hit;
	logic acc_d;

	assign accept = start && (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp = rsp_q;

	// draw addressing: two byte masks of the shifted sprite row
	logic [15:0]   span;
	logic [BW-1:0] bc0, bc1;
	logic [AW-1:0] row_base, addr0, addr1;

	assign span = {bits_q, 8'h00} >> xm_q[2:0];
	assign bc0 = BW'(xm_q >> 3);
	assign bc1 = (bc0 == BW'(ROW_BYTES - 1)) ? '0 : bc0 + 1'b1;
	assign row_base = AW'(row_q * ROW_BYTES);
	assign addr0 = row_base + AW'(bc0);
	assign addr1 = row_base + AW'(bc1);

	// sweep addressing
	logic          asc, last, col_last, col_first;
	logic [AW:0]   up_sum;
	logic          src_ok;
	logic [AW-1:0] src_addr;

	assign asc = (mode_q == SW_CLEAR) || (mode_q == SW_UP) || (mode_q == SW_LEFT);
	assign last = asc ? (i_q == AW'(STORE - 1)) : (i_q == '0);
	assign col_last = (col_q == BW'(ROW_BYTES - 1));
	assign col_first = (col_q == '0);
	assign up_sum = {1'b0, i_q} + {1'b0, moved_q};

	always_comb begin
		src_ok = 1'b0;
		src_addr = i_q;
		unique case (mode_q)
			SW_DOWN: begin
				src_ok = (i_q >= moved_q);
				src_addr = i_q - moved_q;
			end
			SW_UP: begin
				src_ok = (up_sum < (AW + 1)'(STORE));
				src_addr = up_sum[AW-1:0];
			end
			SW_LEFT: begin
				src_ok = !last;
				src_addr = i_q + 1'b1;
			end
			SW_RIGHT: begin
				src_ok = !last;
				src_addr = i_q - 1'b1;
			end
			default: begin
				src_ok = 1'b0;
				src_addr = i_q;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (cmd.op)
						OP_CLEAR: state_d = ST_SW_WR;
						OP_DOWN, OP_UP: begin
							if (cmd.line_count == '0) begin
								state_d = ST_IDLE;
							end else if (int'(cmd.line_count) >= ROWS) begin
								state_d = ST_SW_WR;
							end else begin
								state_d = ST_SW_RD;
							end
						end
						OP_LEFT, OP_RIGHT: state_d = ST_SW_PRIME;
						OP_SPRITE, OP_DIGIT: state_d = ST_DR_RD0;
						OP_READ: state_d = ST_RD_DATA;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_SW_PRIME: state_d = ST_SW_LOAD;
			ST_SW_LOAD: state_d = ST_SW_WR;
			ST_SW_RD: state_d = ST_SW_WR;
			ST_SW_WR: begin
				if (last) begin
					state_d = ST_IDLE;
				end else if (mode_q == SW_CLEAR) begin
					state_d = ST_SW_WR;
				end else begin
					state_d = ST_SW_RD;
				end
			end
			ST_DR_RD0: state_d = ST_DR_WR0;
			ST_DR_WR0: state_d = ST_DR_RD1;
			ST_DR_RD1: state_d = ST_DR_WR1;
			ST_DR_WR1: begin
				state_d = (digit_q && (r_q != DIGIT_LAST_ROW)) ? ST_DR_RD0 : ST_IDLE;
			end
			ST_RD_DATA: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// memory port and completion
	always_comb begin
		mem_re = 1'b0;
		mem_we = 1'b0;
		mem_addr = i_q;
		mem_wdata = '0;
		hit = 1'b0;
		finish = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start && (cmd.op == OP_READ)) begin
					mem_re = 1'b1;
					mem_addr = amod_tab[cmd.byte_address];
				end
				if (start && ((cmd.op == OP_DOWN) || (cmd.op == OP_UP))
						&& (cmd.line_count == '0)) begin
					finish = 1'b1;
				end
			end
			ST_SW_PRIME: begin
				mem_re = 1'b1;
				mem_addr = i_q;
			end
			ST_SW_LOAD, ST_SW_RD: begin
				mem_re = src_ok;
				mem_addr = src_addr;
			end
			ST_SW_WR: begin
				mem_we = 1'b1;
				mem_addr = i_q;
				unique case (mode_q)
					SW_DOWN, SW_UP: mem_wdata = src_ok ? mem_rdata : 8'h00;
					SW_LEFT: mem_wdata = {cur_q[6:0], col_last ? 1'b0 : mem_rdata[7]};
					SW_RIGHT: mem_wdata = {col_first ? 1'b0 : mem_rdata[0], cur_q[7:1]};
					default: mem_wdata = 8'h00;
				endcase
				finish = last && !init_q;
			end
			ST_DR_RD0: begin
				mem_re = 1'b1;
				mem_addr = addr0;
			end
			ST_DR_WR0: begin
				mem_we = 1'b1;
				mem_addr = addr0;
				mem_wdata = mem_rdata ^ span[15:8];
				hit = |(mem_rdata & span[15:8]);
			end
			ST_DR_RD1: begin
				mem_re = 1'b1;
				mem_addr = addr1;
			end
			ST_DR_WR1: begin
				mem_we = 1'b1;
				mem_addr = addr1;
				mem_wdata = mem_rdata ^ span[7:0];
				hit = |(mem_rdata & span[7:0]);
				finish = !(digit_q && (r_q != DIGIT_LAST_ROW));
			end
			ST_RD_DATA: finish = 1'b1;
			default: finish = 1'b0;
		endcase
	end

	assign acc_d = ((state_q == ST_DR_WR1) && !digit_q) ? (acc_q | hit) : acc_q;

	// control registers; reset starts a clearing sweep of the store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SW_WR;
			mode_q <= SW_CLEAR;
			i_q <= '0;
			col_q <= '0;
			init_q <= 1'b1;
			digit_q <= 1'b0;
			r_q <= '0;
			acc_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= finish;
			if (accept) begin
				digit_q <= (cmd.op == OP_DIGIT);
				r_q <= '0;
				if ((cmd.op == OP_SPRITE) && cmd.new_sprite) begin
					acc_q <= 1'b0;
				end
				unique case (cmd.op)
					OP_DOWN: mode_q <= (int'(cmd.line_count) >= ROWS) ? SW_CLEAR : SW_DOWN;
					OP_UP: mode_q <= (int'(cmd.line_count) >= ROWS) ? SW_CLEAR : SW_UP;
					OP_LEFT: mode_q <= SW_LEFT;
					OP_RIGHT: mode_q <= SW_RIGHT;
					default: mode_q <= SW_CLEAR;
				endcase
				if ((cmd.op == OP_DOWN) && (int'(cmd.line_count) < ROWS)
						|| (cmd.op == OP_RIGHT)) begin
					i_q <= AW'(STORE - 1);
					col_q <= BW'(ROW_BYTES - 1);
				end else begin
					i_q <= '0;
					col_q <= '0;
				end
			end
			if (state_q == ST_SW_WR) begin
				i_q <= asc ? i_q + 1'b1 : i_q - 1'b1;
				if (asc) begin
					col_q <= col_last ? '0 : col_q + 1'b1;
				end else begin
					col_q <= col_first ? BW'(ROW_BYTES - 1) : col_q - 1'b1;
				end
				if (last) begin
					init_q <= 1'b0;
				end
			end
			if (((state_q == ST_DR_WR0) || (state_q == ST_DR_WR1)) && !digit_q) begin
				acc_q <= acc_q | hit;
			end
			if ((state_q == ST_DR_WR1) && digit_q && (r_q != DIGIT_LAST_ROW)) begin
				r_q <= r_q + 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			moved_q <= AW'(int'(cmd.line_count) * ROW_BYTES);
			xm_q <= xmod_tab[cmd.x];
			row_q <= ymod_tab[cmd.y];
			fbase_q <= digit_base(cmd.digit_value);
			bits_q <= (cmd.op == OP_DIGIT) ? font_bits(digit_base(cmd.digit_value), 3'd0)
				: sprite_bits(cmd.pattern, cmd.width);
		end
		if ((state_q == ST_SW_LOAD) || (state_q == ST_SW_WR)) begin
			cur_q <= mem_rdata;
		end
		if ((state_q == ST_DR_WR1) && digit_q && (r_q != DIGIT_LAST_ROW)) begin
			row_q <= (row_q == RW'(ROWS - 1)) ? '0 : row_q + 1'b1;
			bits_q <= font_bits(fbase_q, r_q + 1'b1);
		end
		if (finish) begin
			rsp_q.collision <= acc_d;
			rsp_q.read_data <= (state_q == ST_RD_DATA) ? mem_rdata : 8'h00;
		end
	end

endmodule

@@ hw/rtl/mono_framebuffer_sprite_blitter_top.sv @@
// One-bit framebuffer of ROWS x ROW_BYTES*8 pixels in a single-port RAM with
// registered read. A command is taken when start is high and busy is low; its
// result is on rsp for exactly one cycle, marked by done, and cannot be held
// off, so the receiver must take it then. Every byte a sprite or digit touches
// is a RAM read-modify-write. A sprite row touches two bytes and a digit five
// rows; a read and a scroll by zero rows finish without a sweep. Clear and
// scrolls of ROWS or more rows sweep the store at one byte a cycle; vertical
// scrolls read and write each byte in turn, and horizontal ones first prime
// the read of the first byte. After reset busy stays high while the store is
// cleared.
module mono_framebuffer_sprite_blitter_top #(
	parameter int ROW_BYTES = mfb_pkg::ROW_BYTES_DEF,
	parameter int ROWS = mfb_pkg::ROWS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  mfb_pkg::cmd_t cmd,
	output logic          done,
	output mfb_pkg::rsp_t rsp
);

	import mfb_pkg::*;

	localparam int STORE = ROW_BYTES * ROWS;
	localparam int AW = (STORE > 1) ? $clog2(STORE) : 1;

	logic          mem_re, mem_we;
	logic [AW-1:0] mem_addr;
	logic [7:0]    mem_wdata, mem_rdata;

	mfb_ctrl #(
		.ROW_BYTES(ROW_BYTES),
		.ROWS(ROWS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.rsp(rsp),
		.mem_re(mem_re),
		.mem_we(mem_we),
		.mem_addr(mem_addr),
		.mem_wdata(mem_wdata),
		.mem_rdata(mem_rdata)
	);

	mfb_ram #(
		.WIDTH(8),
		.DEPTH(STORE)
	) u_frame (
		.clk(clk),
		.re(mem_re),
		.we(mem_we),
		.addr(mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

endmodule

@@ tb/mono_framebuffer_sprite_blitter_top_tb.sv @@
module mono_framebuffer_sprite_blitter_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mfb_pkg::*;

	localparam int STORE_BYTES = ROW_BYTES_DEF * ROWS_DEF;
	localparam int WDOG_LIMIT = 20000;

	// display predictor and queue of expected responses
	class frame_scoreboard;
		logic [7:0] pixels [STORE_BYTES];
		logic hit_acc;
		rsp_t pending [$];
		int errors;

		function void wipe();
			foreach (pixels[i]) pixels[i] = 8'h00;
			hit_acc = 1'b0;
			pending.delete();
			errors = 0;
		endfunction

		// XOR one row of up to eight pixels, returns 1 when a lit pixel goes dark
		function logic xor_row(logic [5:0] col0, logic [4:0] row, logic [3:0] cnt,
				logic [7:0] bits);
			logic hit;
			int n;
			int col;
			int idx;
			logic [7:0] m;
			hit = 1'b0;
			n = (cnt > 8) ? 8 : cnt;
			for (int w = 0; w < n; w++) begin
				if (bits[7 - w]) begin
					col = (col0 + w) % (ROW_BYTES_DEF * 8);
					idx = row * ROW_BYTES_DEF + col / 8;
					m = 8'h80 >> (col % 8);
					if ((pixels[idx] & m) != 0) hit = 1'b1;
					pixels[idx] ^= m;
				end
			end
			return hit;
		endfunction

		function void note_cmd(cmd_t c);
			rsp_t r;
			logic [7:0] tmp [STORE_BYTES];
			int moved;
			int fb;
			logic [7:0] fbyte;
			r.read_data = 8'h00;
			case (c.op)
				OP_CLEAR: foreach (pixels[i]) pixels[i] = 8'h00;
				OP_DOWN, OP_UP: begin
					if (c.line_count != 0) begin
						moved = ROW_BYTES_DEF * c.line_count;
						tmp = pixels;
						foreach (pixels[i]) begin
							if (c.op == OP_DOWN)
								pixels[i] = (i >= moved) ? tmp[i - moved] : 8'h00;
							else
								pixels[i] = (i + moved < STORE_BYTES) ? tmp[i + moved] : 8'h00;
						end
					end
				end
				OP_LEFT: begin
					tmp = pixels;
					foreach (pixels[i])
						pixels[i] = {tmp[i][6:0], ((i % ROW_BYTES_DEF) == ROW_BYTES_DEF - 1)
							? 1'b0 : tmp[i + 1][7]};
				end
				OP_RIGHT: begin
					tmp = pixels;
					foreach (pixels[i])
						pixels[i] = {((i % ROW_BYTES_DEF) == 0) ? 1'b0 : tmp[i - 1][0],
							tmp[i][7:1]};
				end
				OP_SPRITE: begin
					if (c.new_sprite) hit_acc = 1'b0;
					hit_acc |= xor_row(c.x, c.y, c.width, c.pattern);
				end
				OP_DIGIT: begin
					fb = (c.digit_value % 10) * 3;
					for (int rr = 0; rr < 5; rr++) begin
						fbyte = FONT[fb + rr / 2];
						if (rr % 2) fbyte = {fbyte[3:0], 4'h0};
						void'(xor_row(c.x, 5'(c.y + rr), 4'd4, fbyte));
					end
				end
				default: r.read_data = pixels[c.byte_address];
			endcase
			r.collision = hit_acc;
			pending.push_back(r);
		endfunction

		function void check_rsp(rsp_t got);
			rsp_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected response %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.collision !== want.collision) begin
				$display("%0t: collision expected %b actual %b", $time, want.collision,
					got.collision);
				errors++;
			end
			if (got.read_data !== want.read_data) begin
				$display("%0t: read_data expected %h actual %h", $time, want.read_data,
					got.read_data);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	cmd_t cmd;
	logic done;
	rsp_t rsp;
	frame_scoreboard sb;
	bit gaps_on;
	int idle_cycles;

	mono_framebuffer_sprite_blitter_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .rsp(rsp)
	);

	always begin
		clk = 1'b0; #2;
		clk = 1'b1; #2;
	end

	// monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) sb.check_rsp(rsp);
			if (done || (start && !busy)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// one command transfer, with an optional random gap first; busy is sampled
	// mid-cycle so the accepting edge is found without racing the design
	task automatic send(cmd_t c);
		bit taken;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
		sb.note_cmd(c);
	endtask

	function automatic cmd_t rand_cmd();
		cmd_t c;
		int sel;
		c = '0;
		c.x = 6'($urandom);
		c.y = 5'($urandom);
		c.width = 4'($urandom);
		c.pattern = 8'($urandom);
		c.new_sprite = 1'($urandom);
		c.digit_value = 4'($urandom);
		c.line_count = 5'($urandom);
		c.byte_address = 8'($urandom);
		// mostly drawing and readback, few full-store sweeps
		sel = $urandom_range(0, 99);
		if (sel < 45) c.op = OP_SPRITE;
		else if (sel < 60) c.op = OP_DIGIT;
		else if (sel < 88) c.op = OP_READ;
		else if (sel < 91) c.op = OP_DOWN;
		else if (sel < 94) c.op = OP_UP;
		else if (sel < 96) c.op = OP_LEFT;
		else if (sel < 98) c.op = OP_RIGHT;
		else c.op = OP_CLEAR;
		if ((c.op == OP_DOWN || c.op == OP_UP) && $urandom_range(0, 1))
			c.line_count = 5'($urandom_range(0, 3));
		return c;
	endfunction

	task automatic directed_op(op_t o, logic [5:0] x, logic [4:0] y, logic [3:0] w,
			logic [7:0] p, logic ns, logic [3:0] d, logic [4:0] lc, logic [7:0] a);
		cmd_t c;
		c.op = o; c.x = x; c.y = y; c.width = w; c.pattern = p; c.new_sprite = ns;
		c.digit_value = d; c.line_count = lc; c.byte_address = a;
		send(c);
	endtask

	initial begin
		sb = new();
		sb.wipe();
		idle_cycles = 0;
		gaps_on = 1'b0;
		start = 1'b0;
		cmd = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: wrap, width zero and above eight, digits, scrolls, clear, reads
		directed_op(OP_SPRITE, 6'd60, 5'd31, 4'd8, 8'hff, 1'b1, 4'd0, 5'd0, 8'd0);
		directed_op(OP_SPRITE, 6'd62, 5'd31, 4'd15, 8'hc3, 1'b0, 4'd0, 5'd0, 8'd0);
		directed_op(OP_READ, 6'd0, 5'd0, 4'd0, 8'h00, 1'b0, 4'd0, 5'd0, 8'd255);
		directed_op(OP_READ, 6'd0, 5'd0, 4'd0, 8'h00, 1'b0, 4'd0, 5'd0, 8'd248);
		directed_op(OP_SPRITE, 6'd0, 5'd0, 4'd0, 8'hff, 1'b1, 4'd0, 5'd0, 8'd0);
		directed_op(OP_SPRITE, 6'd3, 5'd0, 4'd1, 8'h80, 1'b0, 4'd0, 5'd0, 8'd0);
		directed_op(OP_DIGIT, 6'd62, 5'd29, 4'd0, 8'h00, 1'b0, 4'd15, 5'd0, 8'd0);
		directed_op(OP_DIGIT, 6'd8, 5'd4, 4'd0, 8'h00, 1'b1, 4'd8, 5'd0, 8'd0);
		directed_op(OP_READ, 6'd0, 5'd0, 4'd0, 8'h00, 1'b0, 4'd0, 5'd0, 8'd33);
		directed_op(OP_DOWN, 6'd0, 5'd0, 4'd0, 8'h00, 1'b0, 4'd0, 5'd0, 8'd0);
		directed_op(OP_DOWN, 6'd0, 5'd0, 4'd0, 8'h00, 1'b0, 4'd0, 5'd1, 8'd0);
		directed_op(OP_READ, 6'd0, 5'd0, 4'd0, 8'h00, 1'b0, 4'd0, 5'd0, 8'd41);
		directed_op(OP_UP, 6'd0, 5'd0, 4'd0, 8'h00, 1'b0, 4'd0, 5'd2, 8'd0);
		directed_op(OP_LEFT, 6'd0, 5'd0, 4'd0, 8'h00, 1'b0, 4'd0, 5'd0, 8'd0);
		directed_op(OP_RIGHT, 6'd0, 5'd0, 4'd0, 8'h00, 1'b0, 4'd0, 5'd0, 8'd0);
		directed_op(OP_RIGHT, 6'd0, 5'd0, 4'd0, 8'h00, 1'b0, 4'd0, 5'd0, 8'd0);
		directed_op(OP_READ, 6'd0, 5'd0, 4'd0, 8'h00, 1'b0, 4'd0, 5'd0, 8'd25);
		directed_op(OP_UP, 6'd0, 5'd0, 4'd0, 8'h00, 1'b0, 4'd0, 5'd31, 8'd0);
		directed_op(OP_SPRITE, 6'd63, 5'd5, 4'd8, 8'ha5, 1'b1, 4'd0, 5'd0, 8'd0);
		directed_op(OP_DOWN, 6'd0, 5'd0, 4'd0, 8'h00, 1'b0, 4'd0, 5'd31, 8'd0);
		directed_op(OP_DIGIT, 6'd0, 5'd0, 4'd0, 8'h00, 1'b0, 4'd9, 5'd0, 8'd0);
		directed_op(OP_CLEAR, 6'd0, 5'd0, 4'd0, 8'h00, 1'b0, 4'd0, 5'd0, 8'd0);
		directed_op(OP_READ, 6'd0, 5'd0, 4'd0, 8'h00, 1'b0, 4'd0, 5'd0, 8'd0);

		// random traffic; hold off once until the queue drains
		gaps_on = 1'b1;
		for (int i = 0; i < 500; i++) begin
			if (i == 200) begin
				start <= 1'b0;
				while (sb.pending.size() != 0) @(posedge clk);
			end
			if (i == 420) gaps_on = 1'b0;
			send(rand_cmd());
		end

		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end
endmodule
